>>> rtl/uft_pkg.sv
`default_nettype none

package uft_pkg;

  localparam int PERIOD_W  = 16;
  localparam int DATA_W    = 8;
  localparam int IDX_W     = 4;
  localparam int BIT_POS_W = 3;
  localparam int CFG_IDX_W = 2;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd868;
  localparam logic [IDX_W-1:0]    BITS_RESET   = 4'd8;
  localparam logic [1:0]          PARITY_RESET = 2'd0;
  localparam logic [1:0]          STOPS_RESET  = 2'd1;

  localparam logic [IDX_W-1:0] BITS_MIN = 4'd5;
  localparam logic [IDX_W-1:0] BITS_MAX = 4'd8;

  localparam logic [CFG_IDX_W-1:0] REG_BIT_PERIOD     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DATA_BIT_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PARITY_MODE    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_STOP_BIT_COUNT = 2'd3;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_START  = 5'b00010,
    PH_DATA   = 5'b00100,
    PH_PARITY = 5'b01000,
    PH_STOP   = 5'b10000
  } phase_t;

  // effective settings after clamping
  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [IDX_W-1:0]    bits;
    logic                parity_en;
    logic                parity_odd;
    logic                two_stops;
  } uft_cfg_t;

  typedef struct packed {
    logic line;
    logic busy;
    logic accepted;
  } tx_res_t;

  typedef struct packed {
    logic              valid;
    logic [DATA_W-1:0] data;
  } rx_res_t;

endpackage

`default_nettype wire

>>> rtl/uft_tx.sv
`default_nettype none

module uft_tx
  import uft_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              step,
  input  wire uft_cfg_t          cfg,
  input  wire logic              mode,
  input  wire logic [DATA_W-1:0] send_byte,
  output tx_res_t                res
);

  phase_t              phase, phase_e, phase_next;
  logic [DATA_W-1:0]   shift, shift_e;
  logic [IDX_W-1:0]    idx, idx_e, idx_next, idx_inc;
  logic [PERIOD_W-1:0] cnt, cnt_e, cnt_next;
  logic                acc, acc_e, acc_next;
  logic                data_bit, bit_end;

  always_comb begin
    phase_e      = phase;
    shift_e      = shift;
    idx_e        = idx;
    cnt_e        = cnt;
    acc_e        = acc;
    res.accepted = 1'b0;
    if (phase == PH_IDLE && mode) begin
      phase_e      = PH_START;
      shift_e      = send_byte;
      idx_e        = '0;
      cnt_e        = '0;
      acc_e        = cfg.parity_odd;
      res.accepted = 1'b1;
    end

    data_bit = shift_e[idx_e[BIT_POS_W-1:0]];
    bit_end  = ({1'b0, cnt_e} + {{PERIOD_W{1'b0}}, 1'b1}) >= {1'b0, cfg.period};
    idx_inc  = idx_e + IDX_W'(1);

    phase_next = phase_e;
    idx_next   = idx_e;
    cnt_next   = cnt_e;
    acc_next   = acc_e;
    res.line   = 1'b1;
    res.busy   = (phase_e != PH_IDLE);

    if (res.busy) begin
      cnt_next = bit_end ? '0 : cnt_e + PERIOD_W'(1);
    end

    unique case (phase_e)
      PH_IDLE: begin
      end
      PH_START: begin
        res.line = 1'b0;
        if (bit_end) begin
          phase_next = PH_DATA;
          idx_next   = '0;
        end
      end
      PH_DATA: begin
        res.line = data_bit;
        if (bit_end) begin
          acc_next = acc_e ^ data_bit;
          idx_next = idx_inc;
          if (idx_inc >= cfg.bits) begin
            phase_next = cfg.parity_en ? PH_PARITY : PH_STOP;
            idx_next   = '0;
          end
        end
      end
      PH_PARITY: begin
        res.line = acc_e;
        if (bit_end) begin
          phase_next = PH_STOP;
          idx_next   = '0;
        end
      end
      PH_STOP: begin
        if (bit_end) begin
          idx_next = idx_inc;
          if (idx_inc >= (cfg.two_stops ? IDX_W'(2) : IDX_W'(1))) begin
            phase_next = PH_IDLE;
            idx_next   = '0;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      shift <= '0;
      idx   <= '0;
      cnt   <= '0;
      acc   <= 1'b0;
    end else if (step) begin
      phase <= phase_next;
      shift <= shift_e;
      idx   <= idx_next;
      cnt   <= cnt_next;
      acc   <= acc_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/uft_rx.sv
`default_nettype none

module uft_rx
  import uft_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     step,
  input  wire uft_cfg_t cfg,
  input  wire logic     rx_line,
  output rx_res_t       res
);

  phase_t              phase, phase_e, phase_next;
  logic [DATA_W-1:0]   shift, shift_e, shift_s, mask;
  logic [IDX_W-1:0]    idx, idx_e, idx_next, idx_inc;
  logic [PERIOD_W-1:0] cnt, cnt_e, cnt_next;
  logic                bit_end;

  always_comb begin
    for (int i = 0; i < DATA_W; i++) begin
      mask[i] = (IDX_W'(i) < cfg.bits);
    end
  end

  always_comb begin
    phase_e = phase;
    shift_e = shift;
    idx_e   = idx;
    cnt_e   = cnt;
    if (phase == PH_IDLE && !rx_line) begin
      phase_e = PH_START;
      shift_e = '0;
      idx_e   = '0;
      cnt_e   = '0;
    end

    // mid-bit sample
    shift_s = shift_e;
    if (phase_e == PH_DATA && cnt_e == (cfg.period >> 1)) begin
      shift_s[idx_e[BIT_POS_W-1:0]] = shift_e[idx_e[BIT_POS_W-1:0]] | rx_line;
    end

    bit_end = ({1'b0, cnt_e} + {{PERIOD_W{1'b0}}, 1'b1}) >= {1'b0, cfg.period};
    idx_inc = idx_e + IDX_W'(1);

    phase_next = phase_e;
    idx_next   = idx_e;
    cnt_next   = cnt_e;
    res.valid  = 1'b0;
    res.data   = '0;

    if (phase_e != PH_IDLE) begin
      cnt_next = bit_end ? '0 : cnt_e + PERIOD_W'(1);
    end

    unique case (phase_e)
      PH_IDLE: begin
      end
      PH_START: begin
        if (bit_end) begin
          phase_next = PH_DATA;
          idx_next   = '0;
        end
      end
      PH_DATA: begin
        if (bit_end) begin
          idx_next = idx_inc;
          if (idx_inc >= cfg.bits) begin
            phase_next = cfg.parity_en ? PH_PARITY : PH_STOP;
            idx_next   = '0;
          end
        end
      end
      PH_PARITY: begin
        if (bit_end) begin
          phase_next = PH_STOP;
          idx_next   = '0;
        end
      end
      PH_STOP: begin
        if (bit_end) begin
          idx_next = idx_inc;
          if (idx_inc >= (cfg.two_stops ? IDX_W'(2) : IDX_W'(1))) begin
            phase_next = PH_IDLE;
            idx_next   = '0;
            res.valid  = 1'b1;
            res.data   = shift_s & mask;
          end
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      shift <= '0;
      idx   <= '0;
      cnt   <= '0;
    end else if (step) begin
      phase <= phase_next;
      shift <= shift_s;
      idx   <= idx_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/uart_frame_transceiver_core.sv
`default_nettype none

// channel   handshake               payload
// in        in_valid / in_ready     mode, send_byte, rx_line
// out       out_valid / out_ready   tx_line, tx_busy, send_accepted, rx_valid, rx_byte
// cfg       cfg_write               cfg_index, cfg_data
//
// one beat per cycle while the out channel is not stalled: a tick is taken and its result is registered the next cycle
// transmitter and receiver state advance only on an accepted in beat
// a stalled out beat holds in_ready low only while out_ready is low
// rst is synchronous and clears state and settings to their defaults

module uart_frame_transceiver_core
  import uft_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 mode,
  input  wire logic [DATA_W-1:0]    send_byte,
  input  wire logic                 rx_line,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      tx_line,
  output logic                      tx_busy,
  output logic                      send_accepted,
  output logic                      rx_valid,
  output logic [DATA_W-1:0]         rx_byte,
  input  wire logic                 cfg_write,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PERIOD_W-1:0]  cfg_data
);

  logic [PERIOD_W-1:0] bit_period;
  logic [IDX_W-1:0]    data_bit_count;
  logic [1:0]          parity_mode;
  logic [1:0]          stop_bit_count;
  uft_cfg_t            cfg;
  tx_res_t             tx_res;
  rx_res_t             rx_res;
  logic                step;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period     <= PERIOD_RESET;
      data_bit_count <= BITS_RESET;
      parity_mode    <= PARITY_RESET;
      stop_bit_count <= STOPS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_BIT_PERIOD:     bit_period     <= cfg_data;
        REG_DATA_BIT_COUNT: data_bit_count <= cfg_data[IDX_W-1:0];
        REG_PARITY_MODE:    parity_mode    <= cfg_data[1:0];
        REG_STOP_BIT_COUNT: stop_bit_count <= cfg_data[1:0];
      endcase
    end
  end

  always_comb begin
    cfg.period = (bit_period == '0) ? PERIOD_W'(1) : bit_period;
    if (data_bit_count < BITS_MIN) begin
      cfg.bits = BITS_MIN;
    end else if (data_bit_count > BITS_MAX) begin
      cfg.bits = BITS_MAX;
    end else begin
      cfg.bits = data_bit_count;
    end
    cfg.parity_en  = (parity_mode != 2'd0);
    cfg.parity_odd = parity_mode[0];
    cfg.two_stops  = stop_bit_count[1];
  end

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  uft_tx u_tx (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .cfg       (cfg),
    .mode      (mode),
    .send_byte (send_byte),
    .res       (tx_res)
  );

  uft_rx u_rx (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .cfg     (cfg),
    .rx_line (rx_line),
    .res     (rx_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      tx_line       <= tx_res.line;
      tx_busy       <= tx_res.busy;
      send_accepted <= tx_res.accepted;
      rx_valid      <= rx_res.valid;
      rx_byte       <= rx_res.data;
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && send_accepted |-> tx_busy)
    else $error("accepted send without busy transmitter");

  a_idle_high: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_busy |-> tx_line)
    else $error("idle transmitter drives low");

  a_rx_byte_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !rx_valid |-> rx_byte == '0)
    else $error("rx_byte nonzero without rx_valid");

  a_step_result: assert property (@(posedge clk) disable iff (rst)
    step |=> out_valid)
    else $error("accepted beat produced no result");

endmodule

`default_nettype wire
